FILE: rtl/bdl_pkg.sv
// Shared types, codes and reset values for the button debouncer.
package bdl_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned CSR_IDX_W = 1;

   typedef enum logic [0:0] {
      CMD_UPDATE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PRESSED  = 3'd1,
      EV_SHORT    = 3'd2,
      EV_RELEASED = 3'd3,
      EV_LONG     = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_idx_type;

   localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = 32'd20;
   localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 32'd1000;

endpackage

FILE: rtl/bdl_req_if.sv
// Request channel: one tick update or one event read per word.
interface bdl_req_if
   import bdl_pkg::*;
();
   logic              valid;
   logic              ready;
   cmd_type           command;
   logic [TIME_W-1:0] now_ms;
   logic              raw_pressed;

   modport source (output valid, output command, output now_ms, output raw_pressed,
                   input ready);
   modport sink   (input valid, input command, input now_ms, input raw_pressed,
                   output ready);
endinterface

FILE: rtl/bdl_rsp_if.sv
// Response channel: latched event and debounced level per word.
interface bdl_rsp_if
   import bdl_pkg::*;
();
   logic      valid;
   logic      ready;
   event_type event_res;
   logic      pressed;

   modport source (output valid, output event_res, output pressed, input ready);
   modport sink   (input valid, input event_res, input pressed, output ready);
endinterface

FILE: rtl/button_debounce_long_press_unit.sv
// Top level of the push-button debouncer with long-press detection.
//
//  channel   direction  handshake       payload
//  req_chan  in         valid/ready     command, now_ms, raw_pressed
//  rsp_chan  out        valid/ready     event_res, pressed
//  csr_*     in         write enable    csr_index, csr_wr_data
//
// Each word passes through the input register and then the output register;
// one word per cycle is sustained while the response is not stalled. The
// timing state updates as a word leaves the input register, so the next word
// sees it. Reset (synchronous) restores the register and state defaults and
// empties both stages. A stalled response holds the output; the input
// register still drains into a free output slot.
module button_debounce_long_press_unit
   import bdl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bdl_req_if.sink              req_chan,
   bdl_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wr_data
);

   logic [TIME_W-1:0] debounce_ff, long_press_ff;

   logic              s1_valid_ff;
   cmd_type           s1_cmd_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              s1_raw_ff;

   logic              prev_raw_ff, prev_raw_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic              long_fired_ff, long_fired_in;
   event_type         pending_ff, pending_in;

   logic              out_valid_ff;
   event_type         out_event_ff, out_event_in;
   logic              out_pressed_ff;

   logic              advance;
   logic              debounce_hit;
   logic [TIME_W-1:0] since_change, held;
   logic              stable_mid;
   logic [TIME_W-1:0] press_mid;
   logic              long_mid;
   event_type         pending_mid;

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.event_res = out_event_ff;
   assign rsp_chan.pressed   = out_pressed_ff;

   always_comb begin
      prev_raw_in    = prev_raw_ff;
      change_time_in = change_time_ff;
      stable_in      = stable_ff;
      press_start_in = press_start_ff;
      long_fired_in  = long_fired_ff;
      pending_in     = pending_ff;
      stable_mid     = stable_ff;
      press_mid      = press_start_ff;
      long_mid       = long_fired_ff;
      pending_mid    = pending_ff;
      debounce_hit   = 1'b0;
      since_change   = '0;
      held           = '0;
      out_event_in   = pending_ff;

      if (s1_cmd_ff == CMD_UPDATE) begin
         if (s1_raw_ff != prev_raw_ff) begin
            change_time_in = s1_now_ff;
         end
         since_change = s1_now_ff - change_time_in;
         debounce_hit = (since_change > debounce_ff) && (s1_raw_ff != stable_ff);
         held         = s1_now_ff - press_start_ff;

         if (debounce_hit) begin
            stable_mid = s1_raw_ff;
            if (s1_raw_ff) begin
               press_mid   = s1_now_ff;
               long_mid    = 1'b0;
               pending_mid = EV_PRESSED;
            end else if (!long_fired_ff && (held != '0)) begin
               pending_mid = EV_SHORT;
            end else begin
               pending_mid = EV_RELEASED;
            end
         end

         stable_in      = stable_mid;
         press_start_in = press_mid;
         long_fired_in  = long_mid;
         pending_in     = pending_mid;
         // a fresh press is excluded by !debounce_hit, so only a held level can fire
         if (stable_mid && !long_mid && !debounce_hit && (held > long_press_ff)) begin
            long_fired_in = 1'b1;
            pending_in    = EV_LONG;
         end
         prev_raw_in  = s1_raw_ff;
         out_event_in = pending_in;
      end else begin
         pending_in = EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         long_press_ff  <= LONG_PRESS_RESET;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         prev_raw_ff    <= 1'b0;
         change_time_ff <= '0;
         stable_ff      <= 1'b0;
         press_start_ff <= '0;
         long_fired_ff  <= 1'b0;
         pending_ff     <= EV_NONE;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_idx_type'(csr_index))
               CSR_DEBOUNCE:   debounce_ff   <= csr_wr_data;
               CSR_LONG_PRESS: long_press_ff <= csr_wr_data;
               default: ;
            endcase
         end

         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end

         if (advance) begin
            out_valid_ff   <= 1'b1;
            prev_raw_ff    <= prev_raw_in;
            change_time_ff <= change_time_in;
            stable_ff      <= stable_in;
            press_start_ff <= press_start_in;
            long_fired_ff  <= long_fired_in;
            pending_ff     <= pending_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: load on handshake or advance, no reset
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_cmd_ff <= req_chan.command;
         s1_now_ff <= req_chan.now_ms;
         s1_raw_ff <= req_chan.raw_pressed;
      end
      if (advance) begin
         out_event_ff   <= out_event_in;
         out_pressed_ff <= stable_in;
      end
   end

`ifndef ASSERT_OFF
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_cmd_ff == CMD_READ) |=> pending_ff == EV_NONE)
      else $error("pending event not cleared after read");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stable_ff) && $stable(long_fired_ff) && $stable(pending_ff))
      else $error("timing state changed without a word advancing");

   a_free_output_ready: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_chan.ready)
      else $error("input stalled while output stage is empty");

   a_level_matches: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && $past(advance) |-> out_pressed_ff == stable_ff)
      else $error("reported level differs from debounced state");
`endif

endmodule
